// ===== hdl/aat_pkg.sv =====
`timescale 1ns / 1ps

package aat_pkg;

  // default coordinate width, signed Q16.16
  localparam int COORD_WIDTH_DEF = 32;

  // configuration port
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_INDEX_W = 3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROT_ROW0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROT_ROW1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROT_ROW2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANS_X  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANS_Y  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANS_Z  = 3'd6;

  // packed coefficient fields
  localparam int FIELD_W = 16;

  // reset values: identity rotation, unit scale
  localparam logic [CFG_DATA_W-1:0] ROT_ROW0_RST = 48'h0000_0000_4000;
  localparam logic [CFG_DATA_W-1:0] ROT_ROW1_RST = 48'h0000_4000_0000;
  localparam logic [CFG_DATA_W-1:0] ROT_ROW2_RST = 48'h4000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] SCALE_RST    = 48'h1000_1000_1000;

  // scale is Q4.12 applied to doubled values, so one extra bit of shift
  localparam int SCALE_SHIFT = 13;
  // rotation is Q2.14
  localparam int ROT_SHIFT   = 14;

endpackage

// ===== hdl/aabb_affine_transform.sv =====
`timescale 1ns / 1ps

// channel  | handshake                    | payload
// ---------+------------------------------+-------------------------------------------
// in       | in_valid / in_ready          | box_min_x..z, box_max_x..z (signed Q16.16)
// out      | out_valid / out_ready        | out_min_x..z, out_max_x..z, saturated
// config   | cfg_wr_en (no wait)          | cfg_index, cfg_data
//
// five register stages: size, scale, rotation terms, sums, corners and clamp
// one beat per cycle sustained while out_ready stays high; each stage holds one box
// a stall on out_ready freezes only the full stages, bubbles ahead still close up
// rst (synchronous) empties the pipe and loads identity rotation, unit scale, zero shift
// config is sampled live by stages 2 to 4, so write it only with the pipe empty

module aabb_affine_transform #(
  parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [aat_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [aat_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       box_min_x,
  input  logic signed [COORD_WIDTH-1:0]       box_min_y,
  input  logic signed [COORD_WIDTH-1:0]       box_min_z,
  input  logic signed [COORD_WIDTH-1:0]       box_max_x,
  input  logic signed [COORD_WIDTH-1:0]       box_max_y,
  input  logic signed [COORD_WIDTH-1:0]       box_max_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_WIDTH-1:0]       out_min_x,
  output logic signed [COORD_WIDTH-1:0]       out_min_y,
  output logic signed [COORD_WIDTH-1:0]       out_min_z,
  output logic signed [COORD_WIDTH-1:0]       out_max_x,
  output logic signed [COORD_WIDTH-1:0]       out_max_y,
  output logic signed [COORD_WIDTH-1:0]       out_max_z,
  output logic                                saturated
);

  localparam int W   = COORD_WIDTH;
  localparam int FW  = aat_pkg::FIELD_W;
  localparam int SSH = aat_pkg::SCALE_SHIFT;
  localparam int RSH = aat_pkg::ROT_SHIFT;
  localparam int NST = 5;        // pipeline depth
  localparam int CW  = W + 4;    // scaled center, signed
  localparam int RW  = W + 3;    // scaled half extent, unsigned
  localparam int EW  = W + 5;    // extent term and extent sum, unsigned
  localparam int PW  = W + 6;    // center term, signed
  localparam int TW  = W + 8;    // center sum, signed
  localparam int OW  = W + 9;    // corner before clamp, signed

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [aat_pkg::CFG_DATA_W-1:0] rot_row [3];
  logic [aat_pkg::CFG_DATA_W-1:0] scale_xyz;
  logic signed [W-1:0]            trans   [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0] <= aat_pkg::ROT_ROW0_RST;
      rot_row[1] <= aat_pkg::ROT_ROW1_RST;
      rot_row[2] <= aat_pkg::ROT_ROW2_RST;
      scale_xyz  <= aat_pkg::SCALE_RST;
      trans[0]   <= '0;
      trans[1]   <= '0;
      trans[2]   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        aat_pkg::REG_ROT_ROW0: rot_row[0] <= cfg_data;
        aat_pkg::REG_ROT_ROW1: rot_row[1] <= cfg_data;
        aat_pkg::REG_ROT_ROW2: rot_row[2] <= cfg_data;
        aat_pkg::REG_SCALE:    scale_xyz  <= cfg_data;
        aat_pkg::REG_TRANS_X:  trans[0]   <= $signed(cfg_data[W-1:0]);
        aat_pkg::REG_TRANS_Y:  trans[1]   <= $signed(cfg_data[W-1:0]);
        aat_pkg::REG_TRANS_Z:  trans[2]   <= $signed(cfg_data[W-1:0]);
        default: ;  // unknown index is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: a stage moves when it is empty or the next one moves
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld;
  logic [NST-1:0] adv;

  always_comb begin
    adv[NST-1] = !vld[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // input corners as per-axis lanes
  logic signed [W-1:0] in_mn [3];
  logic signed [W-1:0] in_mx [3];

  assign in_mn[0] = box_min_x;
  assign in_mn[1] = box_min_y;
  assign in_mn[2] = box_min_z;
  assign in_mx[0] = box_max_x;
  assign in_mx[1] = box_max_y;
  assign in_mx[2] = box_max_z;

  // stage registers
  logic [W-1:0]         s1_dabs [3];   // |max - min|, never reaches 2^W
  logic signed [W:0]    s1_c2   [3];   // min + max, doubled center
  logic [RW-1:0]        s2_r    [3];   // scaled half extent
  logic signed [CW-1:0] s2_c    [3];   // scaled center
  logic [EW-1:0]        s3_et   [3][3];
  logic signed [PW-1:0] s3_ct   [3][3];
  logic [EW-1:0]        s4_ext  [3];
  logic signed [TW-1:0] s4_ctr  [3];
  logic signed [W-1:0]  out_lo  [3];
  logic signed [W-1:0]  out_hi  [3];
  logic [2:0]           sat_lo;
  logic [2:0]           sat_hi;

  for (genvar j = 0; j < 3; j++) begin : g_axis

    // ---- stage 1: size and doubled center ----
    logic signed [W:0] diff;
    logic signed [W:0] diff_abs;

    always_comb begin
      diff     = $signed({in_mx[j][W-1], in_mx[j]}) - $signed({in_mn[j][W-1], in_mn[j]});
      diff_abs = diff[W] ? -diff : diff;
    end

    always_ff @(posedge clk) begin
      if (adv[0]) begin
        s1_dabs[j] <= diff_abs[W-1:0];
        s1_c2[j]   <= $signed({in_mx[j][W-1], in_mx[j]}) + $signed({in_mn[j][W-1], in_mn[j]});
      end
    end

    // ---- stage 2: per-axis scale, floor of the exact product ----
    logic signed [FW-1:0]   s_fld;
    logic signed [FW:0]     s_wide;
    logic [FW-1:0]          s_abs;
    logic [W+FW-1:0]        r_prod;
    logic signed [W+FW:0]   c_prod;

    always_comb begin
      s_fld  = $signed(scale_xyz[FW*j +: FW]);
      s_wide = s_fld[FW-1] ? -$signed({s_fld[FW-1], s_fld}) : $signed({s_fld[FW-1], s_fld});
      s_abs  = s_wide[FW-1:0];
      r_prod = {{FW{1'b0}}, s1_dabs[j]} * {{W{1'b0}}, s_abs};
      c_prod = $signed(s1_c2[j]) * $signed(s_fld);
    end

    always_ff @(posedge clk) begin
      if (adv[1]) begin
        s2_r[j] <= r_prod[W+FW-1:SSH];
        s2_c[j] <= c_prod[W+FW:SSH];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row

    // ---- stage 3: rotation terms, |R| on extents, R on center ----
    for (genvar j = 0; j < 3; j++) begin : g_col
      logic signed [FW-1:0]     r_fld;
      logic signed [FW:0]       r_wide;
      logic [FW-1:0]            r_abs;
      logic [RW+FW-1:0]         e_prod;
      logic signed [CW+FW-1:0]  c_prod;

      always_comb begin
        r_fld  = $signed(rot_row[i][FW*j +: FW]);
        r_wide = r_fld[FW-1] ? -$signed({r_fld[FW-1], r_fld}) : $signed({r_fld[FW-1], r_fld});
        r_abs  = r_wide[FW-1:0];
        e_prod = {{FW{1'b0}}, s2_r[j]} * {{RW{1'b0}}, r_abs};
        c_prod = $signed(s2_c[j]) * $signed(r_fld);
      end

      always_ff @(posedge clk) begin
        if (adv[2]) begin
          s3_et[i][j] <= e_prod[RW+FW-1:RSH];
          s3_ct[i][j] <= c_prod[CW+FW-1:RSH];
        end
      end
    end

    // ---- stage 4: sum the terms, add translation ----
    always_ff @(posedge clk) begin
      if (adv[3]) begin
        s4_ext[i] <= s3_et[i][0] + s3_et[i][1] + s3_et[i][2];
        s4_ctr[i] <= $signed({{(TW-W){trans[i][W-1]}}, trans[i]})
                   + $signed({{(TW-PW){s3_ct[i][0][PW-1]}}, s3_ct[i][0]})
                   + $signed({{(TW-PW){s3_ct[i][1][PW-1]}}, s3_ct[i][1]})
                   + $signed({{(TW-PW){s3_ct[i][2][PW-1]}}, s3_ct[i][2]});
      end
    end

    // ---- stage 5: corners and clamp ----
    logic signed [OW-1:0] lo_full;
    logic signed [OW-1:0] hi_full;
    logic                 lo_fits;
    logic                 hi_fits;
    logic signed [W-1:0]  lo_sat;
    logic signed [W-1:0]  hi_sat;

    always_comb begin
      lo_full = $signed({s4_ctr[i][TW-1], s4_ctr[i]})
              - $signed({{(OW-EW){1'b0}}, s4_ext[i]});
      hi_full = $signed({s4_ctr[i][TW-1], s4_ctr[i]})
              + $signed({{(OW-EW){1'b0}}, s4_ext[i]});
      // value fits when all bits above the coordinate sign agree with it
      lo_fits = (&lo_full[OW-1:W-1]) || !(|lo_full[OW-1:W-1]);
      hi_fits = (&hi_full[OW-1:W-1]) || !(|hi_full[OW-1:W-1]);
      if (lo_fits) begin
        lo_sat = lo_full[W-1:0];
      end else begin
        lo_sat = lo_full[OW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
      if (hi_fits) begin
        hi_sat = hi_full[W-1:0];
      end else begin
        hi_sat = hi_full[OW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
    end

    always_ff @(posedge clk) begin
      if (adv[4]) begin
        out_lo[i] <= lo_sat;
        out_hi[i] <= hi_sat;
        sat_lo[i] <= !lo_fits;
        sat_hi[i] <= !hi_fits;
      end
    end
  end

  assign out_min_x = out_lo[0];
  assign out_min_y = out_lo[1];
  assign out_min_z = out_lo[2];
  assign out_max_x = out_hi[0];
  assign out_max_y = out_hi[1];
  assign out_max_z = out_hi[2];
  assign saturated = (|sat_lo) || (|sat_hi);

endmodule
